### rtl/core/fbmr_pkg.sv
// ----------------------------------------------------------------------------
// fbmr_pkg: shared types and constants of the framed byte mailbox ring
// Item and result structs, command codes, status codes and sizing defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package fbmr_pkg;

	// sizing
	localparam int DEPTH_DEF = 1024;
	localparam int LEN_W     = 16;
	localparam int CMP_W     = LEN_W + 1;	// holds DEPTH and length + header
	localparam int HDR_BYTES = 4;

	// item kinds
	localparam logic [1:0] KIND_BEGIN   = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_READ    = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_TOO_LONG = 3'd1;
	localparam logic [2:0] ST_NO_SPACE = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_NO_MSG   = 3'd4;

	// classified operations handed from front to back
	typedef enum logic [1:0] {
		OP_BEGIN,
		OP_PAYLOAD,
		OP_READ,
		OP_NOP
	} op_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [LEN_W-1:0] msg_length;
		logic [7:0]       data_byte;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] read_byte;
		logic       committed;
	} result_t;

	typedef struct packed {
		op_t              op;
		logic             too_long;
		logic [LEN_W-1:0] msg_length;
		logic [7:0]       data_byte;
	} cmd_t;

endpackage

`default_nettype wire

### rtl/core/fbmr_front.sv
// ----------------------------------------------------------------------------
// fbmr_front: item intake and classification
// Decodes each item into an operation, flags over-long begins, and holds
// the commands in a two-entry queue ahead of the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fbmr_front import fbmr_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t item,
	output logic       full,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  wire logic  cmd_take
);

	cmd_t       slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       wr_en;

	// classify the incoming item
	always_comb begin
		case (item.kind)
			KIND_BEGIN:   cls.op = OP_BEGIN;
			KIND_PAYLOAD: cls.op = OP_PAYLOAD;
			KIND_READ:    cls.op = OP_READ;
			default:      cls.op = OP_NOP;
		endcase
		cls.too_long   = CMP_W'(item.msg_length) > CMP_W'(DEPTH - 5);
		cls.msg_length = item.msg_length;
		cls.data_byte  = item.data_byte;
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[rp_q];
	assign wr_en     = push && !full;

	// queue storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wp_q] <= cls;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wp_q <= !wp_q;
			end
			if (cmd_take) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(wr_en) - 2'(cmd_take);
		end
	end

endmodule

`default_nettype wire

### rtl/core/fbmr_back.sv
// ----------------------------------------------------------------------------
// fbmr_back: ring execution engine
// Owns the ring memory and pointers; runs one command at a time, writes
// header and payload bytes, publishes whole messages and pops bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module fbmr_back import fbmr_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output logic      cmd_take,
	output logic      res_push,
	output result_t   res,
	input  wire logic res_full
);

	localparam int PW = $clog2(DEPTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_HDR  = 2'd1;
	localparam logic [1:0] S_RD   = 2'd2;

	logic [7:0]       ring_q [DEPTH];
	logic [7:0]       rd_data_q;

	logic [1:0]       state_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    pend_q;
	logic [LEN_W-1:0] rem_q;
	logic             open_q;
	logic [1:0]       hdr_idx_q;
	logic [LEN_W-1:0] len_q;
	logic             res_vld_q;
	result_t          res_q;

	logic [CMP_W-1:0] rd_ext;
	logic [CMP_W-1:0] wr_ext;
	logic [CMP_W-1:0] free_sp;
	logic             no_space;
	logic             begin_ok;
	logic             mem_we;
	logic [PW-1:0]    mem_addr;
	logic [7:0]       mem_wdata;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		if (p == PW'(DEPTH - 1)) begin
			return '0;
		end
		return p + PW'(1);
	endfunction

	// free space from the published pointers
	always_comb begin
		rd_ext = CMP_W'(rd_ptr_q);
		wr_ext = CMP_W'(wr_ptr_q);
		if (rd_ext > wr_ext) begin
			free_sp = rd_ext - wr_ext - CMP_W'(1);
		end else begin
			free_sp = rd_ext + CMP_W'(DEPTH) - wr_ext - CMP_W'(1);
		end
		no_space = (CMP_W'(cmd.msg_length) + CMP_W'(HDR_BYTES)) > free_sp;
		begin_ok = !cmd.too_long && !no_space;
	end

	// handshake with the queues on either side
	assign res_push = res_vld_q && !res_full;
	assign res      = res_q;
	assign cmd_take = cmd_valid && (state_q == S_IDLE) && (!res_vld_q || !res_full);

	// memory write port
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = pend_q;
		mem_wdata = 8'h00;
		case (state_q)
			S_IDLE: begin
				if (cmd_take && cmd.op == OP_BEGIN && begin_ok) begin
					mem_we    = 1'b1;
					mem_addr  = wr_ptr_q;
					mem_wdata = cmd.msg_length[7:0];
				end else if (cmd_take && cmd.op == OP_PAYLOAD && open_q) begin
					mem_we    = 1'b1;
					mem_wdata = cmd.data_byte;
				end
			end
			S_HDR: begin
				mem_we    = 1'b1;
				mem_wdata = (hdr_idx_q == 2'd1) ? len_q[15:8] : 8'h00;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// ring memory, read data registered
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_q[mem_addr] <= mem_wdata;
		end
		rd_data_q <= ring_q[rd_ptr_q];
	end

	// command message length, latched on every take and used for the header sequence
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			len_q <= cmd.msg_length;
		end
	end

	// sequencer and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rd_ptr_q  <= '0;
			wr_ptr_q  <= '0;
			pend_q    <= '0;
			rem_q     <= '0;
			open_q    <= 1'b0;
			hdr_idx_q <= 2'd0;
			res_vld_q <= 1'b0;
			res_q     <= '0;
		end else begin
			if (res_push) begin
				res_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						case (cmd.op)
							OP_BEGIN: begin
								open_q <= 1'b0;
								rem_q  <= '0;
								pend_q <= wr_ptr_q;
								if (cmd.too_long) begin
									res_vld_q <= 1'b1;
									res_q     <= '{ST_TOO_LONG, 8'h00, 1'b0};
								end else if (no_space) begin
									res_vld_q <= 1'b1;
									res_q     <= '{ST_NO_SPACE, 8'h00, 1'b0};
								end else begin
									pend_q    <= ptr_next(wr_ptr_q);
									hdr_idx_q <= 2'd1;
									state_q   <= S_HDR;
								end
							end
							OP_PAYLOAD: begin
								res_vld_q <= 1'b1;
								if (!open_q) begin
									res_q <= '{ST_NO_MSG, 8'h00, 1'b0};
								end else begin
									pend_q <= ptr_next(pend_q);
									rem_q  <= rem_q - LEN_W'(1);
									if (rem_q == LEN_W'(1)) begin
										wr_ptr_q <= ptr_next(pend_q);
										open_q   <= 1'b0;
										res_q    <= '{ST_OK, 8'h00, 1'b1};
									end else begin
										res_q <= '{ST_OK, 8'h00, 1'b0};
									end
								end
							end
							OP_READ: begin
								if (rd_ptr_q == wr_ptr_q) begin
									res_vld_q <= 1'b1;
									res_q     <= '{ST_EMPTY, 8'h00, 1'b0};
								end else begin
									rd_ptr_q <= ptr_next(rd_ptr_q);
									state_q  <= S_RD;
								end
							end
							default: begin
								res_vld_q <= 1'b1;
								res_q     <= '{ST_OK, 8'h00, 1'b0};
							end
						endcase
					end
				end
				S_HDR: begin
					pend_q    <= ptr_next(pend_q);
					hdr_idx_q <= hdr_idx_q + 2'd1;
					if (hdr_idx_q == 2'd3) begin
						state_q   <= S_IDLE;
						res_vld_q <= 1'b1;
						if (len_q == '0) begin
							// empty message is published with its header
							wr_ptr_q <= ptr_next(pend_q);
							res_q    <= '{ST_OK, 8'h00, 1'b1};
						end else begin
							rem_q  <= len_q;
							open_q <= 1'b1;
							res_q  <= '{ST_OK, 8'h00, 1'b0};
						end
					end
				end
				S_RD: begin
					state_q   <= S_IDLE;
					res_vld_q <= 1'b1;
					res_q     <= '{ST_OK, rd_data_q, 1'b0};
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/core/fbmr_resq.sv
// ----------------------------------------------------------------------------
// fbmr_resq: result queue
// Two-entry queue that holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
`default_nettype none

module fbmr_resq import fbmr_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    res_push,
	input  wire result_t res,
	output logic         res_full,
	output logic         empty,
	input  wire logic    pop,
	output result_t      result
);

	result_t    slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       rd_en;

	assign res_full = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign result   = slot_q[rp_q];
	assign rd_en    = pop && !empty;

	// queue storage
	always_ff @(posedge clk) begin
		if (res_push) begin
			slot_q[wp_q] <= res;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (res_push) begin
				wp_q <= !wp_q;
			end
			if (rd_en) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(res_push) - 2'(rd_en);
		end
	end

endmodule

`default_nettype wire

### rtl/core/framed_byte_mailbox_ring_unit.sv
// ----------------------------------------------------------------------------
// framed_byte_mailbox_ring_unit: length-prefixed byte mailbox ring
// Begin, payload and read items go through a classifying front queue to an
// execution engine that owns the ring memory; results leave through a queue.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------
//  item in  | push / full              | item   (kind, msg_length, data_byte)
//  result   | pop / empty              | result (status, read_byte, committed)
//
//  Back end: payload, error and ignored items finish in the idle state; a read
//  also passes through S_RD, and an accepted begin through S_HDR (one header
//  byte per cycle through the single ring write port). S_RD picks up the
//  registered memory output. A result goes from the front queue through the
//  back-end result register into the result queue before the result ports.
//  Reset clears pointers, counters and queues at once; ring contents are not
//  cleared, since only published bytes are ever read.
//  A full result queue stalls the back end, which then backs up the front queue.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_byte_mailbox_ring_unit import fbmr_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	output logic       full,
	input  wire item_t item,
	output logic       empty,
	input  wire logic  pop,
	output result_t    result
);

	logic    cmd_valid;
	cmd_t    cmd;
	logic    cmd_take;
	logic    res_push;
	result_t res;
	logic    res_full;

	fbmr_front #(.DEPTH(DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	fbmr_back #(.DEPTH(DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.res_push  (res_push),
		.res       (res),
		.res_full  (res_full)
	);

	fbmr_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

`ifndef SYNTHESIS
	// a published message always reports success
	a_commit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.committed) |-> (result.status == ST_OK))
		else $error("commit reported with error status");

	// only a successful read carries a data byte
	a_byte_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status != ST_OK) |-> (result.read_byte == 8'h00))
		else $error("data byte on failed transaction");

	// the back end never pushes into a full result queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && !pop) |-> !res_full)
		else $error("result queue overflow");
`endif

endmodule

`default_nettype wire

### tb/framed_byte_mailbox_ring_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// framed_byte_mailbox_ring_unit_test: self-checking bench for the mailbox ring
// A queue-fed driver pushes begin, payload, read and ignored items; an
// in-bench mailbox predictor computes each transaction's result, and a
// monitor checks every popped result against the oldest prediction.
// ----------------------------------------------------------------------------

module framed_byte_mailbox_ring_unit_test import fbmr_pkg::*;;

	localparam int DEPTH          = DEPTH_DEF;
	localparam int PTR_W          = $clog2(DEPTH);
	localparam int MAX_MSG        = DEPTH - 5;
	localparam int RANDOM_ITEMS   = 1300;
	localparam int TAIL_ITEMS     = 120;
	localparam int DRAIN_CYCLES   = 20;
	localparam int CYCLE_LIMIT    = 800000;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct {
		item_t itm;
		logic  hold;	// wait for all results before pushing
	} queued_item_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    push = 1'b0;
	logic    full;
	item_t   item = '0;
	logic    empty;
	logic    pop = 1'b0;
	result_t result;

	queued_item_t pending_items[$];
	result_t      expected_mbox_results[$];
	int           fail_count = 0;
	int           item_count = 0;
	int           cycle_count = 0;
	int           send_gap = 0;
	int           pop_gap = 0;
	int           send_odds = 0;
	int           pop_odds = 0;
	logic         hold_next = 1'b0;

	// mailbox state mirrored by the predictor
	logic [7:0]       ring_bytes [DEPTH];
	logic [PTR_W-1:0] rd_ptr;
	logic [PTR_W-1:0] wr_ptr;
	logic [PTR_W-1:0] pend_ptr;
	logic [LEN_W-1:0] bytes_left;
	logic             msg_open;

	framed_byte_mailbox_ring_unit #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (item),
		.empty (empty),
		.pop   (pop),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_mailbox();
		foreach (ring_bytes[i]) ring_bytes[i] = 8'h00;
		rd_ptr     = '0;
		wr_ptr     = '0;
		pend_ptr   = '0;
		bytes_left = '0;
		msg_open   = 1'b0;
	endfunction

	function automatic int ring_free();
		return int'(PTR_W'(rd_ptr - wr_ptr - 1'b1));
	endfunction

	function automatic int ring_used();
		return int'(PTR_W'(wr_ptr - rd_ptr));
	endfunction

	// one transaction through the mailbox: updates state, returns its result
	function automatic result_t predict_mailbox_result(item_t it);
		result_t     r;
		logic [31:0] hdr;
		r = '0;
		case (it.kind)
			KIND_BEGIN: begin
				msg_open   = 1'b0;
				bytes_left = '0;
				pend_ptr   = wr_ptr;
				if (int'(it.msg_length) > MAX_MSG) begin
					r.status = ST_TOO_LONG;
				end else if (int'(it.msg_length) + HDR_BYTES > ring_free()) begin
					r.status = ST_NO_SPACE;
				end else begin
					// little-endian length header
					hdr = 32'(it.msg_length);
					for (int i = 0; i < HDR_BYTES; i++) begin
						ring_bytes[pend_ptr] = hdr[8*i +: 8];
						pend_ptr = pend_ptr + 1'b1;
					end
					if (it.msg_length == '0) begin
						wr_ptr      = pend_ptr;
						r.committed = 1'b1;
					end else begin
						bytes_left = it.msg_length;
						msg_open   = 1'b1;
					end
				end
			end
			KIND_PAYLOAD: begin
				if (!msg_open) begin
					r.status = ST_NO_MSG;
				end else begin
					ring_bytes[pend_ptr] = it.data_byte;
					pend_ptr   = pend_ptr + 1'b1;
					bytes_left = bytes_left - 1'b1;
					if (bytes_left == '0) begin
						wr_ptr      = pend_ptr;
						msg_open    = 1'b0;
						r.committed = 1'b1;
					end
				end
			end
			KIND_READ: begin
				if (rd_ptr == wr_ptr) begin
					r.status = ST_EMPTY;
				end else begin
					r.read_byte = ring_bytes[rd_ptr];
					rd_ptr = rd_ptr + 1'b1;
				end
			end
			default: ;	// unused kind: ignored
		endcase
		return r;
	endfunction

	function automatic item_t make_item(logic [1:0] k, logic [LEN_W-1:0] len, logic [7:0] d);
		item_t it;
		it.kind       = k;
		it.msg_length = len;
		it.data_byte  = d;
		return it;
	endfunction

	// queue an item and advance the planning copy of the mailbox
	task automatic plan(item_t it);
		queued_item_t q;
		q.itm     = it;
		q.hold    = hold_next || ($urandom_range(0, 199) == 0);
		hold_next = 1'b0;
		pending_items.push_back(q);
		void'(predict_mailbox_result(it));
		item_count++;
	endtask

	task automatic plan_reads(int n);
		for (int i = 0; i < n; i++)
			plan(make_item(KIND_READ, LEN_W'($urandom), 8'($urandom)));
	endtask

	// begin, then some payload bytes with reads mixed in
	task automatic plan_message(int len, int sent, int read_pct);
		plan(make_item(KIND_BEGIN, LEN_W'(len), 8'($urandom)));
		for (int i = 0; i < sent; i++) begin
			if ($urandom_range(0, 99) < read_pct)
				plan_reads(1);
			plan(make_item(KIND_PAYLOAD, LEN_W'($urandom), 8'($urandom)));
		end
	endtask

	task automatic plan_directed();
		plan_reads(1);	// read on an empty ring
		plan(make_item(KIND_PAYLOAD, '0, 8'hFF));	// payload with no open message
		plan(make_item(KIND_UNUSED, '1, '1));
		plan(make_item(KIND_BEGIN, '0, '0));	// zero length commits at once
		plan_reads(5);	// header bytes, then empty
		plan(make_item(KIND_BEGIN, LEN_W'(MAX_MSG + 1), '0));
		plan(make_item(KIND_BEGIN, '1, '0));
		plan(make_item(KIND_BEGIN, LEN_W'(MAX_MSG), '0));	// exactly fits an empty ring
		plan(make_item(KIND_PAYLOAD, '1, 8'h00));
		plan(make_item(KIND_BEGIN, LEN_W'(2), '1));	// abandons the open message
		plan(make_item(KIND_PAYLOAD, '0, 8'hFF));
		plan(make_item(KIND_PAYLOAD, '0, 8'h00));
		plan(make_item(KIND_PAYLOAD, '0, 8'h5A));
		plan(make_item(KIND_BEGIN, LEN_W'(ring_free() - 3), '0));	// one byte short of space
		plan(make_item(KIND_BEGIN, LEN_W'(ring_free() - 4), '0));	// exact fit
		plan(make_item(KIND_BEGIN, LEN_W'(1), '0));
		plan(make_item(KIND_PAYLOAD, '0, 8'h81));
		plan_reads(1);
	endtask

	task automatic plan_random();
		int len;
		int sent;
		int read_pct;
		int next_phase;
		int long_items;
		int mark;
		logic long_done;
		read_pct   = 30;
		next_phase = item_count;
		long_items = 0;
		long_done  = 1'b0;
		hold_next  = 1'b1;
		while (item_count - long_items < RANDOM_ITEMS + 25) begin
			// switch at random between filling and draining read mixes every 100 items
			if (item_count >= next_phase) begin
				case ($urandom_range(0, 3))
					0: read_pct = 5;
					1: read_pct = 25;
					2: read_pct = 45;
					default: read_pct = 70;
				endcase
				next_phase = item_count + 100;
			end
			// one long message across the pointer wrap, from an empty ring
			if (!long_done && item_count > 150 && wr_ptr >= 700 && !msg_open) begin
				mark      = item_count;
				hold_next = 1'b1;
				plan_reads(ring_used() + 1);
				len = DEPTH - int'(wr_ptr) + $urandom_range(4, 60);
				plan_message(len, len, 50);
				plan_reads(ring_used() + 1);
				long_items = item_count - mark;
				long_done  = 1'b1;
			end
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
					case ($urandom_range(0, 9))
						0: len = 0;
						1, 2, 3, 4, 5, 6: len = $urandom_range(1, 12);
						7, 8: len = $urandom_range(13, 80);
						default: len = $urandom_range(81, 300);
					endcase
					sent = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
					plan_message(len, sent, read_pct);
				end
				10, 11: begin
					// lengths around the size and space limits
					case ($urandom_range(0, 5))
						0: len = ring_free() - 4;
						1: len = ring_free() - 3;
						2: len = $urandom_range(MAX_MSG + 1, 65535);
						3: len = MAX_MSG - $urandom_range(0, 3);
						4: len = MAX_MSG + 1;
						default: len = $urandom_range(0, 65535);
					endcase
					if (len < 0)
						len = 0;
					sent = $urandom_range(0, 6);
					plan_message(len, (sent < len) ? sent : len, read_pct);
				end
				12, 13, 14, 15: plan_reads($urandom_range(1, 24));
				16, 17: plan(make_item(KIND_PAYLOAD, LEN_W'($urandom), 8'($urandom)));
				18: plan(make_item(KIND_UNUSED, LEN_W'($urandom), 8'($urandom)));
				default: plan(make_item(2'($urandom_range(0, 3)), LEN_W'($urandom),
					8'($urandom)));
			endcase
		end
	endtask

	// driver: push pending items, with idle bursts and drain pauses
	always @(posedge clk) begin
		logic next_push;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			next_push = push;
			if (push && !full) begin
				expected_mbox_results.push_back(predict_mailbox_result(item));
				void'(pending_items.pop_front());
				next_push = 1'b0;
			end
			if (!next_push && pending_items.size() != 0) begin
				if (send_gap != 0) begin
					send_gap--;
				end else if (pending_items[0].hold && expected_mbox_results.size() != 0) begin
					// hold off until every result is back
				end else if (pending_items.size() >= TAIL_ITEMS && send_odds != 0 &&
					$urandom_range(0, send_odds) == 0) begin
					send_gap = $urandom_range(0, 17);
				end else begin
					next_push = 1'b1;
					item <= pending_items[0].itm;
				end
			end
			push <= next_push;
		end
	end

	// monitor: pop results and check them against predictions
	always @(posedge clk) begin
		result_t want;
		logic    next_pop;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_mbox_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %p", $time, result);
					fail_count++;
				end else begin
					want = expected_mbox_results.pop_front();
					if (result.status !== want.status) begin
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, want.status, result.status);
						fail_count++;
					end
					if (result.read_byte !== want.read_byte) begin
						$display("%0t: read_byte mismatch, expected 0x%02h, got 0x%02h",
							$time, want.read_byte, result.read_byte);
						fail_count++;
					end
					if (result.committed !== want.committed) begin
						$display("%0t: committed mismatch, expected %0b, got %0b",
							$time, want.committed, result.committed);
						fail_count++;
					end
				end
			end
			if (pop_gap != 0) begin
				pop_gap--;
				next_pop = 1'b0;
			end else if (pending_items.size() >= TAIL_ITEMS && pop_odds != 0 &&
				$urandom_range(0, pop_odds) == 0) begin
				pop_gap  = $urandom_range(0, 17);
				next_pop = 1'b0;
			end else begin
				next_pop = 1'b1;
			end
			pop <= next_pop;
		end
	end

	// cycle count, idle-rate changes and timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count % 256 == 0) begin
			case ($urandom_range(0, 3))
				0: send_odds <= 0;
				1: send_odds <= 3;
				2: send_odds <= 10;
				default: send_odds <= 30;
			endcase
			case ($urandom_range(0, 3))
				0: pop_odds <= 0;
				1: pop_odds <= 3;
				2: pop_odds <= 10;
				default: pop_odds <= 30;
			endcase
		end
		if (cycle_count == CYCLE_LIMIT) begin
			$display("framed_byte_mailbox_ring_unit_test failed");
			$finish;
		end
	end

	// stimulus plan, reset, and end of run
	initial begin
		clear_mailbox();
		plan_directed();
		plan_random();
		clear_mailbox();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_items.size() != 0 || expected_mbox_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("framed_byte_mailbox_ring_unit_test passed");
		else
			$display("framed_byte_mailbox_ring_unit_test failed");
		$finish;
	end

endmodule
